// File: design/tlvp_pkg.sv
package tlvp_pkg;

    localparam int MAX_DEPTH_DEFAULT   = 15;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // parser phases, which double as byte roles
    localparam logic [2:0] PH_TYPE = 3'd0;
    localparam logic [2:0] PH_NLEN = 3'd1;
    localparam logic [2:0] PH_NAME = 3'd2;
    localparam logic [2:0] PH_LHI  = 3'd3;
    localparam logic [2:0] PH_LLO  = 3'd4;
    localparam logic [2:0] PH_VAL  = 3'd5;
    localparam logic [2:0] ROLE_IGNORED = 3'd6;

    // element type codes
    localparam logic [2:0] KIND_NONE      = 3'd0;
    localparam logic [2:0] KIND_SEC_START = 3'd1;
    localparam logic [2:0] KIND_SEC_END   = 3'd2;
    localparam logic [2:0] KIND_KEY_VALUE = 3'd3;
    localparam logic [2:0] KIND_LIST_START = 3'd4;
    localparam logic [2:0] KIND_LIST_ITEM = 3'd5;
    localparam logic [2:0] KIND_LIST_END  = 3'd6;
    localparam logic [2:0] KIND_END       = 3'd7;

    // error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_CONTEXT     = 3'd1;
    localparam logic [2:0] ERR_UNKNOWN     = 3'd2;
    localparam logic [2:0] ERR_UNPRINTABLE = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED   = 3'd4;
    localparam logic [2:0] ERR_OVERFLOW    = 3'd5;

    localparam logic [3:0] DEPTH_LIMIT = 4'd15;

    // classified request from the front end
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       known;      // 1..7
        logic       printable;  // 0x20..0x7E
        logic       list_type;  // list item or list end
    } tlvp_item_t;

    typedef struct packed {
        logic [2:0] element_kind;
        logic [2:0] byte_role;
        logic [7:0] byte_out;
        logic [3:0] nest_depth;
        logic       inside_list;
        logic       element_end;
        logic       message_end;
        logic [2:0] error_code;
    } tlvp_result_t;

    // handshake between the back end and its two queues
    typedef struct packed {
        logic take;  // pop from item queue
        logic give;  // push to result queue
    } tlvp_ctrl_t;

endpackage

// File: design/tlvp_queue.sv
module tlvp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: design/tlvp_front.sv
module tlvp_front (
    input  logic                [7:0] data_byte,
    input  logic                      last_byte,
    output tlvp_pkg::tlvp_item_t      item
);
    import tlvp_pkg::*;

    // stateless byte classification
    always_comb
    begin
        item.data      = data_byte;
        item.last      = last_byte;
        item.known     = (data_byte >= 8'd1) && (data_byte <= 8'd7);
        item.printable = (data_byte >= 8'h20) && (data_byte <= 8'h7E);
        item.list_type = (data_byte == {5'd0, KIND_LIST_ITEM}) ||
                         (data_byte == {5'd0, KIND_LIST_END});
    end

endmodule

// File: design/tlvp_back.sv
module tlvp_back #(
    parameter int MAX_DEPTH = tlvp_pkg::MAX_DEPTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tlvp_pkg::tlvp_item_t   item,
    input  logic                   item_ready,
    input  logic                   result_room,
    output tlvp_pkg::tlvp_ctrl_t   ctrl,
    output tlvp_pkg::tlvp_result_t result
);
    import tlvp_pkg::*;

    localparam logic [7:0] MAX_D = 8'(MAX_DEPTH);

    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  kind_reg, kind_next;
    logic [15:0] left_reg, left_next;
    logic [7:0]  lhigh_reg, lhigh_next;
    logic [3:0]  depth_reg, depth_next;
    logic        list_reg, list_next;
    logic        halted_reg, halted_next;

    logic        fire;
    logic        ctx_ok;
    logic        name_end;
    logic [15:0] left_dec;
    logic [7:0]  b;

    assign fire         = item_ready && result_room;
    assign ctrl.take    = fire;
    assign ctrl.give    = fire;
    assign b            = item.data;
    assign left_dec     = left_reg - 16'd1;

    always_comb
    begin
        ctx_ok = list_reg ? item.list_type : !item.list_type;
        if ((b == {5'd0, KIND_SEC_END}) && (depth_reg == 4'd0))
        begin
            ctx_ok = 1'b0;
        end
        if ((b == {5'd0, KIND_END}) && ((depth_reg != 4'd0) || list_reg))
        begin
            ctx_ok = 1'b0;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        left_next   = left_reg;
        lhigh_next  = lhigh_reg;
        depth_next  = depth_reg;
        list_next   = list_reg;
        halted_next = halted_reg;
        name_end    = 1'b0;

        result.element_kind = KIND_NONE;
        result.byte_role    = ROLE_IGNORED;
        result.byte_out     = b;
        result.element_end  = 1'b0;
        result.message_end  = item.last;
        result.error_code   = ERR_NONE;

        if (!halted_reg)
        begin
            result.byte_role    = phase_reg;
            result.element_kind = kind_reg;
            case (phase_reg)
                PH_TYPE:
                begin
                    result.element_kind = item.known ? b[2:0] : KIND_NONE;
                    if (!ctx_ok)
                    begin
                        result.error_code = ERR_CONTEXT;
                    end
                    else if (!item.known)
                    begin
                        result.error_code = ERR_UNKNOWN;
                    end
                    else if ((b[2:0] == KIND_SEC_START) &&
                             (({4'd0, depth_reg} >= MAX_D) || (depth_reg >= DEPTH_LIMIT)))
                    begin
                        result.error_code = ERR_OVERFLOW;
                    end
                    else
                    begin
                        kind_next = b[2:0];
                        case (b[2:0])
                            KIND_SEC_START, KIND_KEY_VALUE, KIND_LIST_START:
                            begin
                                phase_next = PH_NLEN;
                            end
                            KIND_LIST_ITEM:
                            begin
                                phase_next = PH_LHI;
                            end
                            KIND_SEC_END:
                            begin
                                depth_next         = depth_reg - 4'd1;
                                result.element_end = 1'b1;
                            end
                            KIND_LIST_END:
                            begin
                                list_next          = 1'b0;
                                result.element_end = 1'b1;
                            end
                            default:
                            begin
                                result.message_end = 1'b1;
                                halted_next        = 1'b1;
                                result.element_end = 1'b1;
                            end
                        endcase
                    end
                end
                PH_NLEN:
                begin
                    left_next = {8'd0, b};
                    if (b == 8'd0)
                    begin
                        name_end = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_NAME;
                    end
                end
                PH_NAME:
                begin
                    if (!item.printable)
                    begin
                        result.error_code = ERR_UNPRINTABLE;
                    end
                    else
                    begin
                        left_next = left_dec;
                        name_end  = (left_dec == 16'd0);
                    end
                end
                PH_LHI:
                begin
                    lhigh_next = b;
                    phase_next = PH_LLO;
                end
                PH_LLO:
                begin
                    left_next = {lhigh_reg, b};
                    if ({lhigh_reg, b} == 16'd0)
                    begin
                        phase_next         = PH_TYPE;
                        result.element_end = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_VAL;
                    end
                end
                default:
                begin
                    left_next = left_dec;
                    if (left_dec == 16'd0)
                    begin
                        phase_next         = PH_TYPE;
                        result.element_end = 1'b1;
                    end
                end
            endcase

            // name complete: key-value moves on to its value
            if (name_end)
            begin
                if (kind_reg == KIND_KEY_VALUE)
                begin
                    phase_next = PH_LHI;
                end
                else
                begin
                    phase_next         = PH_TYPE;
                    result.element_end = 1'b1;
                    if (kind_reg == KIND_SEC_START)
                    begin
                        if (depth_reg < DEPTH_LIMIT)
                        begin
                            depth_next = depth_reg + 4'd1;
                        end
                    end
                    else if (kind_reg == KIND_LIST_START)
                    begin
                        list_next = 1'b1;
                    end
                end
            end

            if ((result.error_code == ERR_NONE) && item.last && (phase_next != PH_TYPE))
            begin
                result.error_code = ERR_TRUNCATED;
            end
            if (result.error_code != ERR_NONE)
            begin
                halted_next = 1'b1;
            end
        end

        result.nest_depth  = depth_next;
        result.inside_list = list_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TYPE;
            kind_reg   <= KIND_NONE;
            left_reg   <= '0;
            lhigh_reg  <= '0;
            depth_reg  <= '0;
            list_reg   <= 1'b0;
            halted_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (item.last)
            begin
                phase_reg  <= PH_TYPE;
                kind_reg   <= KIND_NONE;
                left_reg   <= '0;
                lhigh_reg  <= '0;
                depth_reg  <= '0;
                list_reg   <= 1'b0;
                halted_reg <= 1'b0;
            end
            else
            begin
                phase_reg  <= phase_next;
                kind_reg   <= kind_next;
                left_reg   <= left_next;
                lhigh_reg  <= lhigh_next;
                depth_reg  <= depth_next;
                list_reg   <= list_next;
                halted_reg <= halted_next;
            end
        end
    end

endmodule

// File: design/nested_tlv_message_parser.sv
// Nested TLV message parser: one result per message byte.
// Input side is a queue write port: a request (data_byte, last_byte) is taken at
//   a rising edge with push high and full low. last_byte marks the final byte.
// Result side is a queue read port: while empty is low the oldest result sits on
//   the result ports; it is taken at a rising edge with pop high.
// A taken byte waits in the item queue; the back end parses it and registers its
//   result into the result queue. Throughput: one byte per cycle sustained
//   while bytes arrive and results are popped; the back end parser update sets the rate.
// Structure: a front end classifies each byte and writes it into a small item
//   queue; the back end pops it, runs the parser and writes the result queue.
//   Each queue holds QUEUE_DEPTH entries.
// When pop stays low the result queue fills, the back end stops, then the item
//   queue fills and full rises; nothing is dropped.
// Reset empties both queues and returns the parser to "expect type byte" with
//   zero depth and no list open. The parser also returns there after every byte
//   flagged last_byte.
module nested_tlv_message_parser #(
    parameter int MAX_DEPTH   = tlvp_pkg::MAX_DEPTH_DEFAULT,
    parameter int QUEUE_DEPTH = tlvp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] element_kind,
    output logic [2:0] byte_role,
    output logic [7:0] byte_out,
    output logic [3:0] nest_depth,
    output logic       inside_list,
    output logic       element_end,
    output logic       message_end,
    output logic [2:0] error_code
);
    import tlvp_pkg::*;

    tlvp_item_t   front_item;
    tlvp_item_t   queued_item;
    tlvp_result_t back_result;
    tlvp_result_t head_result;
    tlvp_ctrl_t   back_ctrl;
    logic         item_empty;
    logic         result_full;

    // byte classification
    tlvp_front u_front (
        .data_byte (data_byte),
        .last_byte (last_byte),
        .item      (front_item)
    );

    // decouples input requests from the parser
    tlvp_queue #(
        .WIDTH ($bits(tlvp_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_item),
        .rd_en   (back_ctrl.take),
        .rd_data (queued_item),
        .full    (full),
        .empty   (item_empty)
    );

    // parser state machine
    tlvp_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (queued_item),
        .item_ready  (!item_empty),
        .result_room (!result_full),
        .ctrl        (back_ctrl),
        .result      (back_result)
    );

    // results wait here for the receiver
    tlvp_queue #(
        .WIDTH ($bits(tlvp_result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (back_ctrl.give),
        .wr_data (back_result),
        .rd_en   (pop),
        .rd_data (head_result),
        .full    (result_full),
        .empty   (empty)
    );

    assign element_kind = head_result.element_kind;
    assign byte_role    = head_result.byte_role;
    assign byte_out     = head_result.byte_out;
    assign nest_depth   = head_result.nest_depth;
    assign inside_list  = head_result.inside_list;
    assign element_end  = head_result.element_end;
    assign message_end  = head_result.message_end;
    assign error_code   = head_result.error_code;

endmodule

// File: dv/nested_tlv_message_parser_test.sv
module nested_tlv_message_parser_test;

    import tlvp_pkg::*;

    // The DUT runs with its default depth limit; the 4-bit depth counter caps it at 15.
    localparam int DEPTH_CAP    = (MAX_DEPTH_DEFAULT < 15) ? MAX_DEPTH_DEFAULT : 15;
    localparam int RANDOM_ITEMS = 850;

    // One request as it goes into the parser.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } req_t;

    // One directed row. Where typed is set, want is the result read straight off the
    // message format; other rows take whatever the parser model works out.
    typedef struct packed {
        logic [7:0]   data;
        logic         last;
        logic         typed;
        tlvp_result_t want;
    } stim_row_t;

    typedef enum int {DRAIN_ALL, DRAIN_HALF, DRAIN_TRICKLE} drain_mode_t;

    localparam tlvp_result_t NO_RES = '0;

    // Directed messages, each closed by a request with last set.
    localparam stim_row_t DIRECTED_ROWS [34] = '{
        // unknown type at both ends of the byte range
        '{8'h00, 1'b1, 1'b1,
          '{KIND_NONE, PH_TYPE, 8'h00, 4'd0, 1'b0, 1'b0, 1'b1, ERR_UNKNOWN}},
        '{8'hFF, 1'b1, 1'b1,
          '{KIND_NONE, PH_TYPE, 8'hFF, 4'd0, 1'b0, 1'b0, 1'b1, ERR_UNKNOWN}},
        // section end with no section open, list end with no list open
        '{8'h02, 1'b1, 1'b1,
          '{KIND_SEC_END, PH_TYPE, 8'h02, 4'd0, 1'b0, 1'b0, 1'b1, ERR_CONTEXT}},
        '{8'h06, 1'b1, 1'b1,
          '{KIND_LIST_END, PH_TYPE, 8'h06, 4'd0, 1'b0, 1'b0, 1'b1, ERR_CONTEXT}},
        // well-formed message using every element type
        '{8'h01, 1'b0, 1'b0, NO_RES},   // section start
        '{8'h02, 1'b0, 1'b0, NO_RES},   //   name length 2
        '{8'h20, 1'b0, 1'b0, NO_RES},   //   lowest printable
        '{8'h7E, 1'b0, 1'b0, NO_RES},   //   highest printable, depth goes to 1
        '{8'h03, 1'b0, 1'b0, NO_RES},   // key-value
        '{8'h00, 1'b0, 1'b0, NO_RES},   //   empty name
        '{8'h00, 1'b0, 1'b0, NO_RES},   //   length high
        '{8'h01, 1'b0, 1'b0, NO_RES},   //   length low
        '{8'h5A, 1'b0, 1'b0, NO_RES},   //   value
        '{8'h04, 1'b0, 1'b0, NO_RES},   // list start
        '{8'h00, 1'b0, 1'b0, NO_RES},   //   empty name, list open
        '{8'h05, 1'b0, 1'b0, NO_RES},   // list item
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},   //   zero-length value
        '{8'h06, 1'b0, 1'b0, NO_RES},   // list end
        '{8'h02, 1'b0, 1'b0, NO_RES},   // section end
        '{8'h07, 1'b0, 1'b1,
          '{KIND_END, PH_TYPE, 8'h07, 4'd0, 1'b0, 1'b1, 1'b1, ERR_NONE}},
        // parser stopped: ignored until the last byte
        '{8'h33, 1'b1, 1'b1,
          '{KIND_NONE, ROLE_IGNORED, 8'h33, 4'd0, 1'b0, 1'b0, 1'b1, ERR_NONE}},
        // unknown type inside a list is a context error
        '{8'h04, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h09, 1'b1, 1'b1,
          '{KIND_NONE, PH_TYPE, 8'h09, 4'd0, 1'b1, 1'b0, 1'b1, ERR_CONTEXT}},
        // list item value cut short by the last byte
        '{8'h04, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h05, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h02, 1'b0, 1'b0, NO_RES},
        '{8'h41, 1'b1, 1'b0, NO_RES},
        // control character in a name
        '{8'h03, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b0, 1'b0, NO_RES},
        '{8'h1F, 1'b1, 1'b0, NO_RES}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic [7:0] data_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [2:0] element_kind;
    logic [2:0] byte_role;
    logic [7:0] byte_out;
    logic [3:0] nest_depth;
    logic       inside_list;
    logic       element_end;
    logic       message_end;
    logic [2:0] error_code;

    // Parser model state
    logic [2:0]  parse_phase;
    logic [2:0]  elem_kind;
    logic [15:0] count_left;
    logic [7:0]  len_high;
    logic [3:0]  depth_now;
    logic        list_now;
    logic        stopped;

    tlvp_result_t parse_results_q[$];   // results owed, oldest first
    req_t         outgoing[$];          // requests of the message being sent
    int           failures = 0;
    int           result_count = 0;
    drain_mode_t  drain_mode = DRAIN_ALL;
    int           drain_left = 0;

    always #5 clk = ~clk;

    nested_tlv_message_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .empty        (empty),
        .pop          (pop),
        .element_kind (element_kind),
        .byte_role    (byte_role),
        .byte_out     (byte_out),
        .nest_depth   (nest_depth),
        .inside_list  (inside_list),
        .element_end  (element_end),
        .message_end  (message_end),
        .error_code   (error_code)
    );

    // ---------------------------------------------------------------- parser model

    function automatic void clear_parser();
        parse_phase = PH_TYPE;
        elem_kind   = KIND_NONE;
        count_left  = '0;
        len_high    = '0;
        depth_now   = '0;
        list_now    = 1'b0;
        stopped     = 1'b0;
    endfunction

    // Inside a list only item and list end; outside, never those two.
    // Section end needs an open section; end needs the top level.
    function automatic bit type_allowed(input logic [7:0] b);
        if (list_now) begin
            if (b != KIND_LIST_ITEM && b != KIND_LIST_END)
                return 1'b0;
        end
        else if (b == KIND_LIST_ITEM || b == KIND_LIST_END)
            return 1'b0;
        if (b == KIND_SEC_END && depth_now == 0)
            return 1'b0;
        if (b == KIND_END && (depth_now != 0 || list_now))
            return 1'b0;
        return 1'b1;
    endfunction

    // Name complete: key-value moves on to its value, the others finish here.
    function automatic logic close_name();
        if (elem_kind == KIND_KEY_VALUE) begin
            parse_phase = PH_LHI;
            return 1'b0;
        end
        if (elem_kind == KIND_SEC_START) begin
            if (depth_now < 15)
                depth_now++;
        end
        else if (elem_kind == KIND_LIST_START)
            list_now = 1'b1;
        parse_phase = PH_TYPE;
        return 1'b1;
    endfunction

    function automatic tlvp_result_t parse_byte(input logic [7:0] b, input logic last);
        tlvp_result_t r;
        logic [2:0]   err;
        r             = '0;
        r.byte_role   = ROLE_IGNORED;
        r.byte_out    = b;
        r.message_end = last;
        err           = ERR_NONE;
        if (!stopped) begin
            r.byte_role    = parse_phase;
            r.element_kind = elem_kind;
            case (parse_phase)
                PH_TYPE:
                begin
                    r.element_kind = (b >= 1 && b <= 7) ? b[2:0] : KIND_NONE;
                    if (!type_allowed(b))
                        err = ERR_CONTEXT;
                    else if (b == 0 || b > 7)
                        err = ERR_UNKNOWN;
                    else if (b == KIND_SEC_START && depth_now >= DEPTH_CAP)
                        err = ERR_OVERFLOW;
                    else
                    begin
                        elem_kind = b[2:0];
                        case (b[2:0])
                            KIND_SEC_START, KIND_KEY_VALUE, KIND_LIST_START:
                                parse_phase = PH_NLEN;
                            KIND_LIST_ITEM:
                                parse_phase = PH_LHI;
                            KIND_SEC_END:
                            begin
                                depth_now--;
                                r.element_end = 1'b1;
                            end
                            KIND_LIST_END:
                            begin
                                list_now = 1'b0;
                                r.element_end = 1'b1;
                            end
                            default:
                            begin
                                r.message_end = 1'b1;
                                r.element_end = 1'b1;
                                stopped = 1'b1;
                            end
                        endcase
                    end
                end
                PH_NLEN:
                begin
                    count_left = {8'h00, b};
                    if (b == 0)
                        r.element_end = close_name();
                    else
                        parse_phase = PH_NAME;
                end
                PH_NAME:
                begin
                    if (b < 8'h20 || b > 8'h7E)
                        err = ERR_UNPRINTABLE;
                    else
                    begin
                        count_left--;
                        if (count_left == 0)
                            r.element_end = close_name();
                    end
                end
                PH_LHI:
                begin
                    len_high    = b;
                    parse_phase = PH_LLO;
                end
                PH_LLO:
                begin
                    count_left = {len_high, b};
                    if (count_left == 0)
                    begin
                        parse_phase   = PH_TYPE;
                        r.element_end = 1'b1;
                    end
                    else
                        parse_phase = PH_VAL;
                end
                default:
                begin
                    count_left--;
                    if (count_left == 0)
                    begin
                        parse_phase   = PH_TYPE;
                        r.element_end = 1'b1;
                    end
                end
            endcase
            // last byte mid-element, with nothing worse already flagged
            if (err == ERR_NONE && last && parse_phase != PH_TYPE)
                err = ERR_TRUNCATED;
            if (err != ERR_NONE)
                stopped = 1'b1;
        end
        r.error_code  = err;
        r.nest_depth  = depth_now;
        r.inside_list = list_now;
        if (last)
            clear_parser();
        return r;
    endfunction

    // ---------------------------------------------------------------- message builder

    task automatic add_byte(input logic [7:0] d);
        req_t rq;
        rq.data = d;
        rq.last = 1'b0;
        outgoing.push_back(rq);
    endtask

    task automatic add_name();
        int n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
        add_byte(n[7:0]);
        repeat (n) add_byte(8'($urandom_range(8'h20, 8'h7E)));
    endtask

    // Mostly short values; now and then a huge length that the message then cuts off.
    task automatic add_value(inout bit cut);
        int n;
        if ($urandom_range(0, 15) == 0) begin
            add_byte(8'($urandom_range(1, 255)));
            add_byte(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(0, 255)));
            cut = 1'b1;
        end
        else begin
            n = $urandom_range(0, 6);
            add_byte(8'h00);
            add_byte(n[7:0]);
            repeat (n) add_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic add_key_value(inout bit cut);
        add_byte({5'd0, KIND_KEY_VALUE});
        add_name();
        add_value(cut);
    endtask

    // Builds one message into outgoing: mostly well-formed with random content,
    // sometimes cut short or with one byte spoilt, plus noise and full-depth nests.
    task automatic build_message(input bit deep_first);
        int depth;
        bit in_list;
        bit cut;
        int n_elems;
        int shape;
        int from;
        int k;
        from    = outgoing.size();
        depth   = 0;
        in_list = 1'b0;
        cut     = 1'b0;
        shape   = deep_first ? 10 : $urandom_range(0, 99);
        if (shape < 8) begin
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
        end
        else if (shape < 13) begin
            // fill every level, then one more section start overflows
            repeat (DEPTH_CAP) begin
                add_byte({5'd0, KIND_SEC_START});
                if ($urandom_range(0, 1))
                    add_byte(8'h00);
                else
                    add_name();
            end
            add_byte({5'd0, KIND_SEC_START});
            repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
        end
        else begin
            n_elems = $urandom_range(1, 12);
            for (int i = 0; i < n_elems && !cut; i++) begin
                if (in_list) begin
                    if ($urandom_range(0, 3) == 0) begin
                        add_byte({5'd0, KIND_LIST_END});
                        in_list = 1'b0;
                    end
                    else begin
                        add_byte({5'd0, KIND_LIST_ITEM});
                        add_value(cut);
                    end
                end
                else begin
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            if (depth < DEPTH_CAP) begin
                                add_byte({5'd0, KIND_SEC_START});
                                add_name();
                                depth++;
                            end
                            else begin
                                add_byte({5'd0, KIND_SEC_END});
                                depth--;
                            end
                        end
                        1:
                        begin
                            if (depth > 0) begin
                                add_byte({5'd0, KIND_SEC_END});
                                depth--;
                            end
                            else
                                add_key_value(cut);
                        end
                        2:
                            add_key_value(cut);
                        default:
                        begin
                            add_byte({5'd0, KIND_LIST_START});
                            add_name();
                            in_list = 1'b1;
                        end
                    endcase
                end
            end
            // half the messages close everything and finish with an end element,
            // the rest stop between elements
            if (!cut && $urandom_range(0, 1)) begin
                if (in_list)
                    add_byte({5'd0, KIND_LIST_END});
                repeat (depth) add_byte({5'd0, KIND_SEC_END});
                add_byte({5'd0, KIND_END});
                repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 7) == 0) begin
                k = $urandom_range(from, outgoing.size() - 1);
                while (outgoing.size() > k + 1)
                    void'(outgoing.pop_back());
            end
            if ($urandom_range(0, 7) == 0)
                outgoing[$urandom_range(from, outgoing.size() - 1)].data =
                    8'($urandom_range(0, 255));
        end
        outgoing[outgoing.size() - 1].last = 1'b1;
    endtask

    // ---------------------------------------------------------------- driving

    // Called at a falling edge; returns at the falling edge after the request
    // was taken, with push still high.
    task automatic send_request(input req_t rq, input bit typed, input tlvp_result_t want);
        tlvp_result_t predicted;
        push      <= 1'b1;
        data_byte <= rq.data;
        last_byte <= rq.last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predicted = parse_byte(rq.data, rq.last);
        parse_results_q.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // Waits at falling edges until no result is owed, testing only after each wait.
    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (parse_results_q.size() != 0);
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        failures++;
    endtask

    task automatic check_field(input string field, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      result_count, field, got, want));
    endtask

    initial
    begin : stimulus
        stim_row_t row;
        req_t      rq;
        int        burst_left;
        int        random_sent;
        clear_parser();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_ROWS[i]) begin
            row     = DIRECTED_ROWS[i];
            rq.data = row.data;
            rq.last = row.last;
            send_request(rq, row.typed, row.want);
        end
        // hold off until the parser has handed back every result
        push <= 1'b0;
        wait_for_drain();

        // Random messages, sent in bursts with gaps between them.
        burst_left  = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            build_message(random_sent == 0);
            while (outgoing.size() != 0) begin
                if (burst_left == 0) begin
                    push <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(negedge clk);
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                             : $urandom_range(1, 12);
                end
                send_request(outgoing.pop_front(), 1'b0, NO_RES);
                burst_left--;
                random_sent++;
            end
            if ($urandom_range(0, 39) == 0) begin
                push <= 1'b0;
                wait_for_drain();
            end
        end

        push <= 1'b0;
        wait_for_drain();
        // let the clock run on to catch any stray result
        repeat (8) @(negedge clk);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Receiver: runs of free draining, coin-flip pops and long trickles.
    always @(negedge clk)
    begin : receiver
        if (drain_left == 0) begin
            drain_mode = drain_mode_t'($urandom_range(0, 2));
            drain_left = $urandom_range(20, 150);
        end
        drain_left--;
        case (drain_mode)
            DRAIN_ALL:  pop <= 1'b1;
            DRAIN_HALF: pop <= 1'($urandom_range(0, 1));
            default:    pop <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // A result is taken at every rising edge with pop high and empty low.
    always @(posedge clk)
    begin : check_results
        tlvp_result_t want;
        if (rst_n && pop && !empty) begin
            if (parse_results_q.size() == 0)
                report_mismatch($sformatf("result %0d with none pending, byte_out %02h",
                                          result_count, byte_out));
            else begin
                want = parse_results_q.pop_front();
                check_field("element_kind", element_kind, want.element_kind);
                check_field("byte_role", byte_role, want.byte_role);
                check_field("byte_out", byte_out, want.byte_out);
                check_field("nest_depth", nest_depth, want.nest_depth);
                check_field("inside_list", inside_list, want.inside_list);
                check_field("element_end", element_end, want.element_end);
                check_field("message_end", message_end, want.message_end);
                check_field("error_code", error_code, want.error_code);
            end
            result_count++;
        end
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin : watchdog
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
